[sv/efr_pkg.sv]
package efr_pkg;

    localparam int EASE_BITS = 10;
    localparam int EASE_ONE = 1 << EASE_BITS;

    localparam int VAL_W = 16;
    localparam int TIME_W = 32;

    // Widths of the serial multiply operands and of the step and division counters.
    localparam int T_W = EASE_BITS;
    localparam int SQ_W = 2 * T_W;
    localparam int WGT_W = EASE_BITS + 2;
    localparam int EASE_W = EASE_BITS + 1;
    localparam int PROD_W = SQ_W + WGT_W;
    localparam int MPL_W = WGT_W;
    localparam int STEP_W = $clog2(MPL_W + 1);
    localparam int DIV_CNT_W = $clog2(EASE_BITS + 1);

    localparam logic [VAL_W-1:0] DURATION_RESET = VAL_W'(500);

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SQUARE,
        ST_CUBE,
        ST_SCALE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] mcand;
        logic [MPL_W-1:0]  mplier;
        logic [STEP_W-1:0] steps;
    } mul_req_t;

    typedef struct packed {
        logic              busy;
        logic [PROD_W-1:0] product;
    } mul_sts_t;

endpackage

[sv/efr_mul.sv]
module efr_mul
    import efr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_sts_t sts
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [MPL_W-1:0]  mplier_reg, mplier_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = req.steps;
            acc_next = '0;
            mcand_next = req.mcand;
            mplier_next = req.mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next = {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MPL_W-1:1]};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign sts.busy = busy_reg;
    assign sts.product = acc_reg;

endmodule

[sv/eased_fade_ramp.sv]
// Smoothstep fade generator that works on one beat at a time. A start beat, a tick while no
// fade runs, or a tick that ends the fade is evaluated and its result beat is then loaded into
// the output register. The block takes no next input beat until that load is done. A tick
// inside a running fade is evaluated, then its elapsed time is divided bit-serially by the
// duration into a ten-bit quotient, then three passes through one shared shift-and-add
// multiplier form the square, the cubic weighting and the scaling of the value step, and
// last its result beat is loaded into the output register. These passes shift through
// multipliers of ten, twelve and eleven bits, and each pass hands its product on.
// The next input beat is taken as soon as the previous one is finished, even while its result
// beat still waits at the output. A stalled output holds a finished beat back until the
// previous result beat has left. The user writes the duration register through its own port
// only while the block is idle; the block itself does not enforce this. A running fade keeps
// the duration it started with.
module eased_fade_ramp
    import efr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [VAL_W-1:0]  fade_duration,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [VAL_W-1:0]  target,
    input  logic [TIME_W-1:0] now_time,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [VAL_W-1:0]  current_value,
    output logic              fading
);

    localparam logic [WGT_W-1:0] THREE_ONE = WGT_W'(3 * EASE_ONE);

    state_t             state_reg, state_next;
    logic [VAL_W-1:0]   duration_reg, duration_next;
    logic               active_reg, active_next;
    logic [TIME_W-1:0]  start_time_reg, start_time_next;
    logic [VAL_W-1:0]   held_reg, held_next;
    logic [VAL_W-1:0]   from_reg, from_next;
    logic [VAL_W-1:0]   to_reg, to_next;
    logic [VAL_W-1:0]   present_reg, present_next;
    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   out_value_reg, out_value_next;
    logic               out_fading_reg, out_fading_next;
    logic               op_reg, op_next;
    logic [VAL_W-1:0]   target_reg, target_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [VAL_W-1:0]   rem_reg, rem_next;
    logic [T_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [TIME_W-1:0]  elapsed;
    logic [VAL_W:0]     rem_shift;
    logic [VAL_W:0]     rem_diff;
    logic [T_W-1:0]     quo_step;
    logic [WGT_W-1:0]   weight;
    logic [EASE_W-1:0]  eased;
    logic [VAL_W-1:0]   delta_mag;
    logic [VAL_W-1:0]   step_mag;
    logic               accept;
    mul_req_t           mul_req;
    mul_sts_t           mul_sts;

    efr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .sts   (mul_sts)
    );

    assign accept = in_valid && !in_stall;
    assign elapsed = now_reg - start_time_reg;
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff = rem_shift - {1'b0, held_reg};
    assign weight = THREE_ONE - WGT_W'({quo_reg, 1'b0});
    assign eased = mul_sts.product[2*EASE_BITS +: EASE_W];
    assign delta_mag = (to_reg >= from_reg) ? (to_reg - from_reg) : (from_reg - to_reg);
    assign step_mag = mul_sts.product[EASE_BITS +: VAL_W];

    always_comb
    begin
        state_next = state_reg;
        duration_next = duration_reg;
        active_next = active_reg;
        start_time_next = start_time_reg;
        held_next = held_reg;
        from_next = from_reg;
        to_next = to_reg;
        present_next = present_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_fading_next = out_fading_reg;
        op_next = op_reg;
        target_next = target_reg;
        now_next = now_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_cnt_next = div_cnt_reg;
        quo_step = {quo_reg[T_W-2:0], !rem_diff[VAL_W]};
        mul_req = '0;

        if (cfg_valid && cfg_ready)
        begin
            duration_next = fade_duration;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next = operation;
                    target_next = target;
                    now_next = now_time;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_OUT;
                if (op_reg == OP_START)
                begin
                    if (target_reg == present_reg || duration_reg == '0)
                    begin
                        active_next = 1'b0;
                        start_time_next = '0;
                        held_next = '0;
                        from_next = target_reg;
                        to_next = target_reg;
                        present_next = target_reg;
                    end
                    else
                    begin
                        active_next = 1'b1;
                        start_time_next = now_reg;
                        held_next = duration_reg;
                        from_next = present_reg;
                        to_next = target_reg;
                    end
                end
                else if (active_reg)
                begin
                    if (held_reg == '0 || elapsed >= TIME_W'(held_reg))
                    begin
                        active_next = 1'b0;
                        start_time_next = '0;
                        held_next = '0;
                        from_next = to_reg;
                        present_next = to_reg;
                    end
                    else
                    begin
                        rem_next = elapsed[VAL_W-1:0];
                        quo_next = '0;
                        div_cnt_next = DIV_CNT_W'(EASE_BITS);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = rem_diff[VAL_W] ? rem_shift[VAL_W-1:0] : rem_diff[VAL_W-1:0];
                quo_next = quo_step;
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(1))
                begin
                    mul_req.start = 1'b1;
                    mul_req.mcand = PROD_W'(quo_step);
                    mul_req.mplier = MPL_W'(quo_step);
                    mul_req.steps = STEP_W'(T_W);
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (!mul_sts.busy)
                begin
                    mul_req.start = 1'b1;
                    mul_req.mcand = mul_sts.product;
                    mul_req.mplier = MPL_W'(weight);
                    mul_req.steps = STEP_W'(WGT_W);
                    state_next = ST_CUBE;
                end
            end
            ST_CUBE:
            begin
                if (!mul_sts.busy)
                begin
                    mul_req.start = 1'b1;
                    mul_req.mcand = PROD_W'(delta_mag);
                    mul_req.mplier = MPL_W'(eased);
                    mul_req.steps = STEP_W'(EASE_W);
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (!mul_sts.busy)
                begin
                    if (to_reg >= from_reg)
                    begin
                        present_next = from_reg + step_mag;
                    end
                    else
                    begin
                        present_next = from_reg - step_mag;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = present_reg;
                    out_fading_next = active_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            duration_reg <= DURATION_RESET;
            active_reg <= 1'b0;
            start_time_reg <= '0;
            held_reg <= '0;
            from_reg <= '0;
            to_reg <= '0;
            present_reg <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            duration_reg <= duration_next;
            active_reg <= active_next;
            start_time_reg <= start_time_next;
            held_reg <= held_next;
            from_reg <= from_next;
            to_reg <= to_next;
            present_reg <= present_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_fading_reg <= out_fading_next;
        op_reg <= op_next;
        target_reg <= target_next;
        now_reg <= now_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign current_value = out_value_reg;
    assign fading = out_fading_reg;

`ifndef SYNTHESIS
    // A running fade always has a nonzero latched duration.
    a_active_duration: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (held_reg != '0))
        else $error("fade active with zero duration");

    // The division remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < held_reg))
        else $error("division remainder out of range");

    // The multiplier is quiet whenever no tick is being worked on.
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_OUT || state_reg == ST_EVAL)
            |-> !mul_sts.busy)
        else $error("multiplier busy outside a tick");

    // An accepted beat is evaluated in the next cycle.
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EVAL))
        else $error("accepted beat not evaluated");
`endif

endmodule
